// File: rtl/tdtsw_pkg.sv
// ----------------------------------------------------------------------------
// tdtsw_pkg: shared definitions for the target-sum window pair finder
// Widths fixed by the channel words, the sequencer states and the codes and
// structs that pass between the sequencer and the shared arithmetic unit.
// ----------------------------------------------------------------------------
package tdtsw_pkg;

    // Fixed widths of the channel words.
    localparam int VALUE_W     = 16;
    localparam int TARGET_W    = 32;
    localparam int TOTAL_LEN_W = 12;

    // The window sum never exceeds the target plus one element.
    localparam int SUM_W = 33;

    // Sequencer states, one-hot.
    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_SHRINK = 4'b0010,
        S_PAIR   = 4'b0100,
        S_DONE   = 4'b1000
    } state_t;

    // Operations of the shared arithmetic unit.
    typedef enum logic [1:0] {
        ALU_PASS = 2'd0,
        ALU_ADD  = 2'd1,
        ALU_SUB  = 2'd2
    } alu_op_t;

    // Request from the sequencer to the arithmetic unit.
    typedef struct packed {
        alu_op_t              op;
        logic [VALUE_W-1:0]   operand;
    } alu_req_t;

    // Compare results of the current window sum against the target.
    typedef struct packed {
        logic sum_gt;
        logic sum_eq;
    } alu_flags_t;

endpackage

// File: rtl/tdtsw_if.sv
// ----------------------------------------------------------------------------
// tdtsw channel interfaces
// Valid/ready channels for input words, result words and target writes.
// ----------------------------------------------------------------------------
interface tdtsw_item_if import tdtsw_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] value;
    logic               last;

    modport source (output valid, output value, output last, input ready);
    modport sink   (input valid, input value, input last, output ready);
endinterface

interface tdtsw_result_if import tdtsw_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic                   found;
    logic [TOTAL_LEN_W-1:0] total_length;
    logic                   overflow;

    modport source (output valid, output found, output total_length, output overflow,
                    input ready);
    modport sink   (input valid, input found, input total_length, input overflow,
                    output ready);
endinterface

interface tdtsw_cfg_if import tdtsw_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [TARGET_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/tdtsw_alu.sv
// ----------------------------------------------------------------------------
// tdtsw_alu: shared window-sum adder and comparator
// Adds a new element to, or removes the oldest element from, the window sum,
// and compares the current sum against the target.
// ----------------------------------------------------------------------------
module tdtsw_alu
    import tdtsw_pkg::*;
(
    input  logic [SUM_W-1:0]    sum,
    input  logic [TARGET_W-1:0] target,
    input  alu_req_t            req,
    output logic [SUM_W-1:0]    result,
    output alu_flags_t          flags
);

    logic [SUM_W-1:0] operand_ext;
    logic [SUM_W-1:0] target_ext;

    assign operand_ext = SUM_W'(req.operand);
    assign target_ext  = SUM_W'(target);

    // One adder serves both the growing and the shrinking of the window.
    always_comb
    begin
        unique case (req.op)
            ALU_ADD:  result = sum + operand_ext;
            ALU_SUB:  result = sum - operand_ext;
            ALU_PASS: result = sum;
            default:  result = sum;
        endcase
    end

    // Compare of the stored sum against the target.
    assign flags.sum_gt = sum > target_ext;
    assign flags.sum_eq = sum == target_ext;

endmodule

// File: rtl/two_disjoint_target_sum_windows.sv
// ----------------------------------------------------------------------------
// two_disjoint_target_sum_windows: shortest pair of disjoint target-sum windows
// Sliding-window search over a stored sequence, reporting the smallest total
// length of two non-overlapping windows that each sum to the target.
// ----------------------------------------------------------------------------
// Each input word is taken in the idle state, then the window is shrunk from
// the left one element per cycle through a single shared adder, and a final
// pairing state pairs the match with the best earlier one and updates the
// prefix store. No new word is taken until the block is back in the idle
// state, and each element leaves the window at most once. A word with the last
// mark set then passes through a done state that hands over the result word,
// and a word that arrives when the store is full is flagged and dropped
// without shrinking or pairing. The element and prefix stores are read through
// registered ports, which sets the one-element-per-cycle pace of the shrink
// loop. No clearing pass is needed after reset. The result word waits in an
// output register, so a new sequence may start while it is still pending.
// ----------------------------------------------------------------------------
module two_disjoint_target_sum_windows
    import tdtsw_pkg::*;
#(
    parameter int MAX_ITEMS  = 1024,
    parameter int VALUE_BITS = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    tdtsw_item_if.sink           item,
    tdtsw_result_if.source       result,
    tdtsw_cfg_if.sink            cfg
);

    // Element width after masking, store address and count widths.
    localparam int EW = (VALUE_BITS < VALUE_W) ? VALUE_BITS : VALUE_W;
    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int PW = CW + 1;

    state_t             state_reg, state_next;
    logic [TARGET_W-1:0] target_reg;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [CW-1:0]      ws_reg, ws_next;
    logic [CW-1:0]      we_reg, we_next;
    logic [PW-1:0]      best_reg, best_next;
    logic               ovf_reg, ovf_next;
    logic               last_reg, last_next;
    logic [CW-1:0]      prev_reg, prev_next;

    logic                   res_valid_reg, res_valid_next;
    logic                   res_found_reg, res_found_next;
    logic [TOTAL_LEN_W-1:0] res_total_reg, res_total_next;
    logic                   res_ovf_reg, res_ovf_next;

    logic [EW-1:0] elem_mem [MAX_ITEMS];
    logic [EW-1:0] elem_rd_reg;
    logic [CW-1:0] pref_mem [MAX_ITEMS];
    logic [CW-1:0] pref_rd_reg;

    logic          elem_wr;
    logic [AW-1:0] elem_waddr;
    logic [AW-1:0] elem_raddr;
    logic          pref_wr;
    logic [AW-1:0] pref_waddr;
    logic [AW-1:0] pref_raddr;
    logic [CW-1:0] pref_raddr_full;
    logic [CW-1:0] pref_wdata;

    alu_req_t         alu_req;
    alu_flags_t       alu_flags;
    logic [SUM_W-1:0] alu_result;

    logic          accept;
    logic          full;
    logic          win_nonempty;
    logic          shrink_go;
    logic          match;
    logic [CW-1:0] win_len;
    logic [PW-1:0] cand;
    logic [CW-1:0] here;
    logic          out_free;

    // Shared adder and comparator for the window sum.
    tdtsw_alu u_alu
    (
        .sum    (sum_reg),
        .target (target_reg),
        .req    (alu_req),
        .result (alu_result),
        .flags  (alu_flags)
    );

    // Handshake and status terms.
    assign item.ready   = state_reg == S_IDLE;
    assign accept       = item.valid && item.ready;
    assign full         = we_reg == CW'(MAX_ITEMS);
    assign win_nonempty = ws_reg <= we_reg;
    assign shrink_go    = (state_reg == S_SHRINK) && alu_flags.sum_gt && win_nonempty;
    assign out_free     = !res_valid_reg || result.ready;
    assign cfg.ready    = 1'b1;

    assign result.valid        = res_valid_reg;
    assign result.found        = res_found_reg;
    assign result.total_length = res_total_reg;
    assign result.overflow     = res_ovf_reg;

    // Arithmetic unit request: add the new word, or drop the oldest element.
    always_comb
    begin
        alu_req.op      = ALU_PASS;
        alu_req.operand = '0;
        if (accept && !full)
        begin
            alu_req.op      = ALU_ADD;
            alu_req.operand = VALUE_W'(item.value[EW-1:0]);
        end
        else if (shrink_go)
        begin
            alu_req.op      = ALU_SUB;
            alu_req.operand = VALUE_W'(elem_rd_reg);
        end
    end

    // Store addressing. The element store is read ahead at the next window
    // start; the prefix store is read at the previous end, and at the entry
    // before the window once the shrink loop has finished.
    assign ws_next         = shrink_go ? ws_reg + CW'(1) : ws_reg;
    assign elem_wr         = accept && !full;
    assign elem_waddr      = we_reg[AW-1:0];
    assign elem_raddr      = ws_next[AW-1:0];
    assign pref_raddr_full = ((state_reg == S_SHRINK) && !shrink_go) ?
                             (ws_reg - CW'(1)) : (we_reg - CW'(1));
    assign pref_raddr      = pref_raddr_full[AW-1:0];
    assign pref_wr         = state_reg == S_PAIR;
    assign pref_waddr      = we_reg[AW-1:0];
    assign pref_wdata      = here;

    // Match and pairing terms for the finished window.
    assign match   = win_nonempty && alu_flags.sum_eq;
    assign win_len = we_reg - ws_reg + CW'(1);
    assign cand    = PW'(win_len) + PW'(pref_rd_reg);

    // Shortest match ending here or earlier.
    always_comb
    begin
        here = match ? win_len : '0;
        if ((we_reg != '0) && (prev_reg != '0) && ((here == '0) || (prev_reg < here)))
        begin
            here = prev_reg;
        end
    end

    // Sequencer.
    always_comb
    begin
        state_next     = state_reg;
        sum_next       = sum_reg;
        we_next        = we_reg;
        best_next      = best_reg;
        ovf_next       = ovf_reg;
        last_next      = last_reg;
        prev_next      = prev_reg;
        res_valid_next = res_valid_reg && !result.ready;
        res_found_next = res_found_reg;
        res_total_next = res_total_reg;
        res_ovf_next   = res_ovf_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (full)
                    begin
                        ovf_next   = 1'b1;
                        state_next = item.last ? S_DONE : S_IDLE;
                    end
                    else
                    begin
                        sum_next   = alu_result;
                        last_next  = item.last;
                        state_next = S_SHRINK;
                    end
                end
            end
            S_SHRINK:
            begin
                sum_next = alu_result;
                if (!shrink_go)
                begin
                    prev_next  = pref_rd_reg;
                    state_next = S_PAIR;
                end
            end
            S_PAIR:
            begin
                if (match && (ws_reg != '0) && (pref_rd_reg != '0) &&
                    ((best_reg == '0) || (cand < best_reg)))
                begin
                    best_next = cand;
                end
                we_next    = we_reg + CW'(1);
                state_next = last_reg ? S_DONE : S_IDLE;
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    res_valid_next = 1'b1;
                    res_found_next = best_reg != '0;
                    res_total_next = TOTAL_LEN_W'(best_reg);
                    res_ovf_next   = ovf_reg;
                    sum_next       = '0;
                    we_next        = '0;
                    best_next      = '0;
                    ovf_next       = 1'b0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control and sequence registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            target_reg    <= TARGET_W'(1);
            sum_reg       <= '0;
            ws_reg        <= '0;
            we_reg        <= '0;
            best_reg      <= '0;
            ovf_reg       <= 1'b0;
            last_reg      <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            ws_reg        <= (state_reg == S_DONE && out_free) ? '0 : ws_next;
            we_reg        <= we_next;
            best_reg      <= best_next;
            ovf_reg       <= ovf_next;
            last_reg      <= last_next;
            res_valid_reg <= res_valid_next;
            if (cfg.valid)
            begin
                target_reg <= cfg.data;
            end
        end
    end

    // Payload registers of the result word and the held prefix value.
    always_ff @(posedge clk)
    begin
        prev_reg      <= prev_next;
        res_found_reg <= res_found_next;
        res_total_reg <= res_total_next;
        res_ovf_reg   <= res_ovf_next;
    end

    // Element store, with the new word forwarded when read at once.
    always_ff @(posedge clk)
    begin
        if (elem_wr)
        begin
            elem_mem[elem_waddr] <= item.value[EW-1:0];
        end
        if (elem_wr && (elem_waddr == elem_raddr))
        begin
            elem_rd_reg <= item.value[EW-1:0];
        end
        else
        begin
            elem_rd_reg <= elem_mem[elem_raddr];
        end
    end

    // Prefix store of the shortest match ending at or before each index.
    always_ff @(posedge clk)
    begin
        if (pref_wr)
        begin
            pref_mem[pref_waddr] <= pref_wdata;
        end
        pref_rd_reg <= pref_mem[pref_raddr];
    end

endmodule

// File: tb/sv/tdtsw_pair_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdtsw_pair_check: prediction and checking of the window pair reports
// Watches the input word, result word and target channels of the window pair
// finder. It keeps its own copy of the sliding window, the element store and
// the shortest-match store, predicts one report per sequence, and compares
// every result word field by field with the oldest outstanding report.
// ----------------------------------------------------------------------------
module tdtsw_pair_check
    import tdtsw_pkg::*;
#(
    parameter int STORE_DEPTH = 1024
)
(
    input  logic    clk,
    input  logic    rst_n,
    tdtsw_item_if   item,
    tdtsw_result_if result,
    tdtsw_cfg_if    cfg,
    output int      mismatches,
    output int      pending_reports,
    output int      reports_checked
);

    localparam int LEN_W = $clog2(STORE_DEPTH) + 1;

    // One expected report, laid out as the result word.
    typedef struct packed {
        logic                   found;
        logic [TOTAL_LEN_W-1:0] total_length;
        logic                   overflow;
    } pair_report_t;

    // Predicted state of the finder.
    logic [VALUE_W-1:0]     elem_store    [STORE_DEPTH];
    logic [LEN_W-1:0]       shortest_upto [STORE_DEPTH];
    logic [SUM_W-1:0]       win_sum = '0;
    int                     win_start = 0;
    int                     win_end = 0;
    logic [TOTAL_LEN_W-1:0] best_pair = '0;
    logic                   seq_overflow = 1'b0;
    logic [TARGET_W-1:0]    target = 1;

    pair_report_t report_q [$];
    int           fail_count = 0;
    int           seen_count = 0;

    // Zero stands for no match, so the smaller of two lengths ignores it.
    function automatic logic [TOTAL_LEN_W-1:0] shorter_of(
        input logic [TOTAL_LEN_W-1:0] a,
        input logic [TOTAL_LEN_W-1:0] b
    );
        if (a == 0)
            return b;
        if (b == 0)
            return a;
        return (a < b) ? a : b;
    endfunction

    function automatic void clear_sequence();
        win_sum      = '0;
        win_start    = 0;
        win_end      = 0;
        best_pair    = '0;
        seq_overflow = 1'b0;
    endfunction

    // Adds one element, shrinks the window, and records the shortest match so far.
    function automatic void take_word(input logic [VALUE_W-1:0] v);
        int                     pos;
        logic [TOTAL_LEN_W-1:0] here;
        logic [TOTAL_LEN_W-1:0] len;
        logic [TOTAL_LEN_W-1:0] prior;
        pos = win_end;
        here = '0;
        elem_store[pos] = v;
        win_sum = win_sum + SUM_W'(v);
        while (win_sum > SUM_W'(target) && win_start <= pos)
        begin
            win_sum = win_sum - SUM_W'(elem_store[win_start]);
            win_start++;
        end
        // A non-empty window on target pairs with the best match ending before it.
        if (win_start <= pos && win_sum == SUM_W'(target))
        begin
            len = TOTAL_LEN_W'(pos - win_start + 1);
            if (win_start > 0)
            begin
                prior = TOTAL_LEN_W'(shortest_upto[win_start - 1]);
                if (prior != 0)
                    best_pair = shorter_of(best_pair, len + prior);
            end
            here = len;
        end
        if (pos > 0)
            here = shorter_of(here, TOTAL_LEN_W'(shortest_upto[pos - 1]));
        shortest_upto[pos] = LEN_W'(here);
        win_end = pos + 1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        pair_report_t want;
        if (!rst_n)
        begin
            clear_sequence();
            target = 1;
            report_q.delete();
            fail_count = 0;
            seen_count = 0;
            mismatches      <= 0;
            pending_reports <= 0;
            reports_checked <= 0;
        end
        else
        begin
            // Result words are checked before this edge's input word is predicted.
            if (result.valid && result.ready)
            begin
                if (report_q.size() == 0)
                begin
                    fail_count++;
                    $display("%0t: unexpected result word: found=%0b total_length=%0d overflow=%0b",
                             $time, result.found, result.total_length, result.overflow);
                end
                else
                begin
                    want = report_q.pop_front();
                    seen_count++;
                    if (result.found !== want.found)
                    begin
                        fail_count++;
                        $display("%0t: found mismatch: expected %0b, got %0b",
                                 $time, want.found, result.found);
                    end
                    if (result.total_length !== want.total_length)
                    begin
                        fail_count++;
                        $display("%0t: total_length mismatch: expected %0d, got %0d",
                                 $time, want.total_length, result.total_length);
                    end
                    if (result.overflow !== want.overflow)
                    begin
                        fail_count++;
                        $display("%0t: overflow mismatch: expected %0b, got %0b",
                                 $time, want.overflow, result.overflow);
                    end
                end
            end

            // A target write takes effect from the next word on.
            if (cfg.valid && cfg.ready)
                target = cfg.data;

            // Input word: store it while there is room, report on the last mark.
            if (item.valid && item.ready)
            begin
                if (win_end < STORE_DEPTH)
                    take_word(item.value);
                else
                    seq_overflow = 1'b1;
                if (item.last)
                begin
                    want.found        = (best_pair != 0);
                    want.total_length = best_pair;
                    want.overflow     = seq_overflow;
                    report_q.push_back(want);
                    clear_sequence();
                end
            end

            mismatches      <= fail_count;
            pending_reports <= report_q.size();
            reports_checked <= seen_count;
        end
    end

endmodule

// File: tb/sv/two_disjoint_target_sum_windows_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_disjoint_target_sum_windows_test: top of the window pair finder bench
// Drives sequences of words and target writes into the finder, with random
// idling on both channels, a long result stall and a store overflow, and
// leaves prediction and comparison to the pair checker beside the block.
// ----------------------------------------------------------------------------
module two_disjoint_target_sum_windows_test;
    import tdtsw_pkg::*;

    localparam int STORE_DEPTH    = 1024;
    localparam int RANDOM_WORDS   = 250;
    localparam int OVERFLOW_WORDS = STORE_DEPTH + 6;
    // A word that empties a full window holds the block until every element is dropped.
    localparam int SETTLE_CYCLES  = STORE_DEPTH + 76;
    localparam int DRAIN_CYCLES   = 64;
    localparam int LONG_STALL     = 400;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PLANT_LIMIT    = 131070;
    localparam logic [TARGET_W-1:0] TARGET_MAX = '1;

    logic clk = 1'b0;
    logic rst_n;

    int src_idle_pct;
    int snk_idle_pct;
    int stalls_asked;
    int words_sent = 0;
    int sequences_sent = 0;
    int targets_set = 0;
    int mismatches;
    int pending_reports;
    int reports_checked;

    logic [TARGET_W-1:0] cur_target = 1;
    logic [VALUE_W-1:0]  seq_vals [$];

    tdtsw_item_if   item_ch ();
    tdtsw_result_if result_ch ();
    tdtsw_cfg_if    cfg_ch ();

    two_disjoint_target_sum_windows #(
        .MAX_ITEMS  (STORE_DEPTH),
        .VALUE_BITS (VALUE_W)
    ) uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    tdtsw_pair_check #(
        .STORE_DEPTH (STORE_DEPTH)
    ) pair_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .item            (item_ch),
        .result          (result_ch),
        .cfg             (cfg_ch),
        .mismatches      (mismatches),
        .pending_reports (pending_reports),
        .reports_checked (reports_checked)
    );

    // Clock of 4 ns period.
    always #2 clk = ~clk;

    // Result receiver: random idling, plus a long hold-off whenever one is asked for.
    initial
    begin : result_receiver
        int stall_left;
        int stalls_granted;
        stall_left = 0;
        stalls_granted = 0;
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
                result_ch.ready <= 1'b0;
            else if (stall_left > 0)
            begin
                stall_left--;
                result_ch.ready <= 1'b0;
            end
            else if (stalls_granted != stalls_asked)
            begin
                stalls_granted++;
                stall_left = LONG_STALL;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
        end
    end

    // Watchdog: ends the run when no channel has moved a word for too long.
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

    // Offers one word after a random gap and holds it until it is taken.
    task automatic send_word(input logic [VALUE_W-1:0] v, input logic is_last);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.value <= v;
        item_ch.last  <= is_last;
        do
            @(posedge clk);
        while (!item_ch.ready);
        words_sent++;
        if (is_last)
            sequences_sent++;
    endtask

    task automatic send_sequence();
        for (int i = 0; i < seq_vals.size(); i++)
            send_word(seq_vals[i], i == seq_vals.size() - 1);
    endtask

    // Pauses the sender until every predicted report has come back.
    task automatic drain_reports();
        item_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_reports != 0);
    endtask

    // The block may still be shrinking after a word without the last mark.
    task automatic set_target(input logic [TARGET_W-1:0] t);
        drain_reports();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= t;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        cur_target = t;
        targets_set++;
    endtask

    function automatic logic [TARGET_W-1:0] pick_target();
        logic [TARGET_W-1:0] t;
        case ($urandom_range(0, 7))
            0: t = 1;
            1: t = 2;
            2: t = $urandom_range(3, 30);
            3: t = $urandom_range(31, 2000);
            4: t = 65535;
            5: t = $urandom_range(65536, PLANT_LIMIT);
            6: t = TARGET_MAX;
            default:
            begin
                t = $urandom;
                if (t == 0)
                    t = 1;
            end
        endcase
        return t;
    endfunction

    // Filler values: mostly within reach of the target, some zeros, some anything.
    function automatic logic [VALUE_W-1:0] noise_value(input logic [TARGET_W-1:0] tgt);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 20)
            return VALUE_W'($urandom);
        if (roll < 30)
            return '0;
        if (tgt < 65535)
            return VALUE_W'($urandom_range(0, tgt));
        return VALUE_W'($urandom_range(32768, 65535));
    endfunction

    // Appends a run of one to three or more words that sums exactly to the target.
    task automatic plant_window(input logic [TARGET_W-1:0] tgt);
        logic [TARGET_W-1:0] rest;
        logic [TARGET_W-1:0] part;
        rest = tgt;
        repeat ($urandom_range(0, 2))
        begin
            part = $urandom_range(0, (rest > 65535) ? 65535 : rest);
            seq_vals.push_back(VALUE_W'(part));
            rest = rest - part;
        end
        while (rest > 65535)
        begin
            seq_vals.push_back('1);
            rest = rest - 65535;
        end
        seq_vals.push_back(VALUE_W'(rest));
    endtask

    // Mostly sequences built from target windows and filler, the rest pure noise.
    task automatic build_sequence(input logic [TARGET_W-1:0] tgt);
        int pieces;
        int shape;
        seq_vals.delete();
        pieces = $urandom_range(1, 5);
        shape = $urandom_range(0, 99);
        repeat (pieces)
        begin
            if (shape < 75 && tgt <= PLANT_LIMIT && $urandom_range(0, 3) != 0)
                plant_window(tgt);
            else
                repeat ($urandom_range(1, 3)) seq_vals.push_back(noise_value(tgt));
        end
    endtask

    task automatic random_phase(input int words);
        int first;
        int seqs;
        first = words_sent;
        seqs = 0;
        while (words_sent - first < words)
        begin
            if (seqs > 0 && seqs % 8 == 0)
                set_target(pick_target());
            build_sequence(cur_target);
            send_sequence();
            seqs++;
        end
    endtask

    task automatic directed_checks();
        // Target of one after reset: two single-element windows around a zero.
        seq_vals = '{16'd1, 16'd0, 16'd1};
        send_sequence();
        // A lone word of the largest value cannot form a pair.
        seq_vals = '{16'hFFFF};
        send_sequence();
        set_target(65535);
        seq_vals = '{16'hFFFF, 16'd0, 16'hFFFF};
        send_sequence();
        // Target changed part way through a sequence.
        set_target(5);
        send_word(16'd2, 1'b0);
        send_word(16'd3, 1'b0);
        send_word(16'd1, 1'b0);
        set_target(4);
        seq_vals = '{16'd3, 16'd4, 16'hFFFF, 16'd4, 16'd0};
        send_sequence();
        // Largest target: out of reach of any short sequence.
        set_target(TARGET_MAX);
        seq_vals = '{16'hFFFF, 16'hFFFF, 16'hFFFF};
        send_sequence();
        set_target(1);
        seq_vals = '{16'd1, 16'd1};
        send_sequence();
        // Store full: the words beyond the depth are dropped and flagged.
        set_target(3);
        seq_vals.delete();
        repeat (OVERFLOW_WORDS) seq_vals.push_back(VALUE_W'($urandom_range(0, 3)));
        send_sequence();
        // The next sequence starts clean.
        seq_vals = '{16'd3, 16'd3};
        send_sequence();
    endtask

    initial
    begin : stimulus
        item_ch.valid <= 1'b0;
        item_ch.value <= '0;
        item_ch.last  <= 1'b0;
        cfg_ch.valid  <= 1'b0;
        cfg_ch.data   <= '0;
        rst_n         <= 1'b0;
        src_idle_pct  <= 35;
        snk_idle_pct  <= 80;
        stalls_asked  <= 0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        directed_checks();

        set_target(pick_target());
        random_phase(RANDOM_WORDS / 3);

        // Roles swapped: the sender idles more than the receiver.
        src_idle_pct <= 80;
        snk_idle_pct <= 35;
        set_target(pick_target());
        random_phase(RANDOM_WORDS / 3);

        // No idling; the receiver holds off while the sender keeps offering words.
        set_target($urandom_range(2, 12));
        src_idle_pct <= 0;
        snk_idle_pct <= 0;
        stalls_asked <= stalls_asked + 1;
        random_phase(RANDOM_WORDS - 2 * (RANDOM_WORDS / 3));

        drain_reports();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d words in %0d sequences with %0d target writes,", words_sent,
                 sequences_sent, targets_set);
        $display("a store overflow, a mid-sequence target change and a %0d-cycle stall; %0d %s",
                 LONG_STALL, reports_checked, "reports compared.");
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

// File: filelist.f
rtl/tdtsw_pkg.sv
rtl/tdtsw_if.sv
rtl/tdtsw_alu.sv
rtl/two_disjoint_target_sum_windows.sv
tb/sv/tdtsw_pair_check.sv
tb/sv/two_disjoint_target_sum_windows_test.sv
